>>> sv/mvmb_pkg.sv
// Shared constants, types and fixed-point helpers for the matrix builder.
`timescale 1ns / 1ps
package mvmb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 16;
    localparam int QB         = ANGLE_BITS - 2;
    localparam int SW         = FRAC_BITS + 2;
    localparam int RW         = FRAC_BITS + 3;
    localparam int PW         = RW + 33;
    localparam int TW         = 34;
    localparam int HORNER_N   = 5;

    localparam logic [ANGLE_BITS-1:0] QUARTER  = ANGLE_BITS'(1) << QB;
    localparam logic signed [31:0]    ONE_F    = 32'sd1 <<< FRAC_BITS;
    localparam logic [1:0]            LAST_COL = 2'd3;

    localparam logic signed [31:0] SIN_COEF [6] = '{
        32'sd1686629713, -32'sd693598669, 32'sd85569306,
        -32'sd5026997, 32'sd172273, -32'sd3864
    };

    typedef logic signed [31:0]   word_t;
    typedef logic signed [SW-1:0] sin_t;
    typedef logic signed [RW-1:0] ent_t;
    typedef ent_t rot_mat_t [3][3];

    typedef struct packed {
        logic  mode;
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t scl_x;
        word_t scl_y;
        word_t scl_z;
    } side_t;

    typedef struct packed {
        logic [31:0] v;
        logic        f;
    } sat_t;

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m = (mag + (64'd1 << (sh - 1))) >> sh;
        rnd_shift = v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647)
        begin
            r.v = 32'h7FFF_FFFF;
            r.f = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            r.v = 32'h8000_0000;
            r.f = 1'b1;
        end
        else
        begin
            r.v = v[31:0];
            r.f = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> sv/mvmb_horner_cell.sv
// One Horner step of the sine polynomial: t <= coef + x2*t (Q30).
`timescale 1ns / 1ps
module mvmb_horner_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    coef,
    input  logic [1:0]            q_in,
    input  logic [30:0]           x_in,
    input  logic signed [31:0]    x2_in,
    input  logic signed [mvmb_pkg::TW-1:0] t_in,
    output logic [1:0]            q,
    output logic [30:0]           x,
    output logic signed [31:0]    x2,
    output logic signed [mvmb_pkg::TW-1:0] t
);
    import mvmb_pkg::*;

    logic [1:0]            q_reg;
    logic [30:0]           x_reg;
    logic signed [31:0]    x2_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [TW-1:0]  t_next;
    logic signed [63:0]    prod;
    logic signed [63:0]    acc;

    always_comb
    begin
        prod   = x2_in * t_in;
        acc    = 64'(coef) + rnd_shift(prod, 30);
        t_next = acc[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg  <= q_in;
            x_reg  <= x_in;
            x2_reg <= x2_in;
            t_reg  <= t_next;
        end
    end

    assign q  = q_reg;
    assign x  = x_reg;
    assign x2 = x2_reg;
    assign t  = t_reg;

endmodule

>>> sv/mvmb_sine.sv
// Sine pipeline: quarter-wave fold, chain of Horner cells, final scale and sign.
`timescale 1ns / 1ps
module mvmb_sine (
    input  logic                           clk,
    input  logic                           en,
    input  logic [mvmb_pkg::ANGLE_BITS-1:0] angle,
    output mvmb_pkg::sin_t                 s
);
    import mvmb_pkg::*;

    localparam logic [QB:0] QUARTER_R = (QB + 1)'(1) << QB;

    logic [1:0]           qa;
    logic [QB:0]          r;
    logic [30:0]          xa;
    logic signed [31:0]   xs;
    logic signed [63:0]   xx;
    logic signed [63:0]   x2w;

    logic [1:0]           q_c  [HORNER_N+1];
    logic [30:0]          x_c  [HORNER_N+1];
    logic signed [31:0]   x2_c [HORNER_N+1];
    logic signed [TW-1:0] t_c  [HORNER_N+1];

    logic [1:0]           q_reg;
    logic [30:0]          x_reg;
    logic signed [31:0]   x2_reg;
    logic signed [TW-1:0] t_reg;

    logic signed [31:0]   xf;
    logic signed [63:0]   pf;
    logic signed [63:0]   sf;
    logic signed [63:0]   sc;
    logic signed [63:0]   sr;
    sin_t                 s_reg;
    sin_t                 s_next;

    always_comb
    begin
        qa = angle[ANGLE_BITS-1 -: 2];
        r  = {1'b0, angle[QB-1:0]};
        if (qa[0])
        begin
            r = QUARTER_R - r;
        end
        xa  = 31'(r) << (30 - QB);
        xs  = {1'b0, xa};
        xx  = xs * xs;
        x2w = rnd_shift(xx, 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg  <= qa;
            x_reg  <= xa;
            x2_reg <= x2w[31:0];
            t_reg  <= TW'(SIN_COEF[HORNER_N]);
        end
    end

    assign q_c[0]  = q_reg;
    assign x_c[0]  = x_reg;
    assign x2_c[0] = x2_reg;
    assign t_c[0]  = t_reg;

    for (genvar k = 0; k < HORNER_N; k++)
    begin : g_cell
        mvmb_horner_cell u_cell (
            .clk   (clk),
            .en    (en),
            .coef  (SIN_COEF[HORNER_N-1-k]),
            .q_in  (q_c[k]),
            .x_in  (x_c[k]),
            .x2_in (x2_c[k]),
            .t_in  (t_c[k]),
            .q     (q_c[k+1]),
            .x     (x_c[k+1]),
            .x2    (x2_c[k+1]),
            .t     (t_c[k+1])
        );
    end

    always_comb
    begin
        xf = {1'b0, x_c[HORNER_N]};
        pf = xf * t_c[HORNER_N];
        sf = rnd_shift(pf, 30);
        sc = sf;
        if (sf < 0)
        begin
            sc = '0;
        end
        else if (sf > (64'sd1 <<< 30))
        begin
            sc = 64'sd1 <<< 30;
        end
        sr = rnd_shift(sc, 30 - FRAC_BITS);
        s_next = q_c[HORNER_N][1] ? SW'(-sr) : SW'(sr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule

>>> sv/mvmb_rotation.sv
// Two-stage build of R = Rz*Ry*Rx from the six sines and cosines.
`timescale 1ns / 1ps
module mvmb_rotation (
    input  logic               clk,
    input  logic               en,
    input  mvmb_pkg::sin_t     sx,
    input  mvmb_pkg::sin_t     cx,
    input  mvmb_pkg::sin_t     sy,
    input  mvmb_pkg::sin_t     cy,
    input  mvmb_pkg::sin_t     sz,
    input  mvmb_pkg::sin_t     cz,
    output mvmb_pkg::rot_mat_t rot
);
    import mvmb_pkg::*;

    logic signed [2*SW-1:0] p_cxsz_reg, p_sxsz_reg, p_cxcz_reg, p_sxcz_reg;
    ent_t sxsy_reg, cxsy_reg, sz_reg, cz_reg;
    ent_t r00_reg, r10_reg, r20_reg, r21_reg, r22_reg;
    rot_mat_t rot_reg;

    logic signed [63:0] t_sxsy, t_cxsy, t00, t10, t21, t22;
    logic signed [63:0] a01, a02, a11, a12;

    always_comb
    begin
        t_sxsy = rnd_shift(64'(sx * sy), FRAC_BITS);
        t_cxsy = rnd_shift(64'(cx * sy), FRAC_BITS);
        t00    = rnd_shift(64'(cy * cz), FRAC_BITS);
        t10    = rnd_shift(64'(cy * sz), FRAC_BITS);
        t21    = rnd_shift(64'(sx * cy), FRAC_BITS);
        t22    = rnd_shift(64'(cx * cy), FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxsy_reg   <= RW'(t_sxsy);
            cxsy_reg   <= RW'(t_cxsy);
            r00_reg    <= RW'(t00);
            r10_reg    <= RW'(t10);
            r20_reg    <= RW'(-sy);
            r21_reg    <= RW'(t21);
            r22_reg    <= RW'(t22);
            p_cxsz_reg <= cx * sz;
            p_sxsz_reg <= sx * sz;
            p_cxcz_reg <= cx * cz;
            p_sxcz_reg <= sx * cz;
            sz_reg     <= RW'(sz);
            cz_reg     <= RW'(cz);
        end
    end

    // second stage: sums of exact products, rounded once
    always_comb
    begin
        a01 = rnd_shift(64'(sxsy_reg * cz_reg) - 64'(p_cxsz_reg), FRAC_BITS);
        a02 = rnd_shift(64'(cxsy_reg * cz_reg) + 64'(p_sxsz_reg), FRAC_BITS);
        a11 = rnd_shift(64'(sxsy_reg * sz_reg) + 64'(p_cxcz_reg), FRAC_BITS);
        a12 = rnd_shift(64'(cxsy_reg * sz_reg) - 64'(p_sxcz_reg), FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg[0][0] <= r00_reg;
            rot_reg[0][1] <= RW'(a01);
            rot_reg[0][2] <= RW'(a02);
            rot_reg[1][0] <= r10_reg;
            rot_reg[1][1] <= RW'(a11);
            rot_reg[1][2] <= RW'(a12);
            rot_reg[2][0] <= r20_reg;
            rot_reg[2][1] <= r21_reg;
            rot_reg[2][2] <= r22_reg;
        end
    end

    assign rot = rot_reg;

endmodule

>>> sv/mvmb_column.sv
// Column stage: scale or translation products, then rounding and clipping.
`timescale 1ns / 1ps
module mvmb_column (
    input  logic               clk,
    input  logic               en,
    input  mvmb_pkg::rot_mat_t rot,
    input  mvmb_pkg::side_t    side,
    output logic [31:0]        cols [4][4],
    output logic [3:0]         col_sat
);
    import mvmb_pkg::*;

    logic signed [32:0]   opnd [3];
    logic signed [PW-1:0] prod_reg [3][3];
    rot_mat_t             rot_reg;
    side_t                side_reg;
    logic signed [63:0]   acc;
    sat_t                 sv;

    always_comb
    begin
        if (side.mode)
        begin
            opnd[0] = -33'(side.pos_x);
            opnd[1] = -33'(side.pos_y);
            opnd[2] = -33'(side.pos_z);
        end
        else
        begin
            opnd[0] = 33'(side.scl_x);
            opnd[1] = 33'(side.scl_y);
            opnd[2] = 33'(side.scl_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= rot[i][j] * opnd[j];
                end
            end
            rot_reg  <= rot;
            side_reg <= side;
        end
    end

    always_comb
    begin
        col_sat = '0;
        for (int j = 0; j < 3; j++)
        begin
            cols[j][3] = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (side_reg.mode)
                begin
                    cols[j][i] = 32'(rot_reg[i][j]);
                end
                else
                begin
                    sv = sat32(rnd_shift(64'(prod_reg[i][j]), FRAC_BITS));
                    cols[j][i] = sv.v;
                    col_sat[j] = col_sat[j] | sv.f;
                end
            end
        end
        cols[3][3] = ONE_F;
        if (side_reg.mode)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = 64'(prod_reg[i][0]) + 64'(prod_reg[i][1]) + 64'(prod_reg[i][2]);
                sv  = sat32(rnd_shift(acc, FRAC_BITS));
                cols[3][i] = sv.v;
                col_sat[3] = col_sat[3] | sv.f;
            end
        end
        else
        begin
            acc = '0;
            sv  = '0;
            cols[3][0] = side_reg.pos_x;
            cols[3][1] = side_reg.pos_y;
            cols[3][2] = side_reg.pos_z;
        end
    end

endmodule

>>> sv/model_view_matrix_builder_core.sv
// Top level: sine cell chains, rotation, column stage and column output buffer.
//
//  port group | dir | payload
//  s_*        | in  | one transform (mode in tuser, position/angles/scale in tdata)
//  m_*        | out | one matrix column per beat, tlast on column 3
//
// Each input item leaves as four output beats, one column per beat, so the
// one-column-per-beat output port sets the throughput. The whole pipeline
// advances together and holds while the output buffer still has columns to
// send. Reset clears the valid chain, the buffer valid flag and the column
// counter only.
`timescale 1ns / 1ps
module model_view_matrix_builder_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
    input  logic [239:0] s_tdata,
    // mode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row0, row1, row2, row3
    output logic [127:0] m_tdata,
    // column[1:0], saturated
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import mvmb_pkg::*;

    localparam int SIDE_N = 9;
    localparam int VAL_N  = 10;

    logic adv;
    logic beat;

    side_t side_in;
    side_t side_reg [1:SIDE_N];
    logic  valid_reg [1:VAL_N];

    logic [ANGLE_BITS-1:0] ax, ay, az;
    sin_t sx, cx, sy, cy, sz, cz;
    rot_mat_t rot;

    logic [31:0] cols [4][4];
    logic [3:0]  col_sat;
    logic [31:0] buf_reg [4][4];
    logic [3:0]  buf_sat_reg;
    logic        buf_valid_reg;
    logic [1:0]  col_reg;

    assign beat     = m_tvalid && m_tready;
    assign adv      = !buf_valid_reg || (beat && col_reg == LAST_COL);
    assign s_tready = adv;

    always_comb
    begin
        side_in.mode  = s_tuser[0];
        side_in.pos_x = s_tdata[31:0];
        side_in.pos_y = s_tdata[63:32];
        side_in.pos_z = s_tdata[95:64];
        side_in.scl_x = s_tdata[175:144];
        side_in.scl_y = s_tdata[207:176];
        side_in.scl_z = s_tdata[239:208];
        ax = ANGLE_BITS'(s_tdata[111:96]);
        ay = ANGLE_BITS'(s_tdata[127:112]);
        az = ANGLE_BITS'(s_tdata[143:128]);
        // view mode uses the negated angles
        if (s_tuser[0])
        begin
            ax = ANGLE_BITS'(0) - ax;
            ay = ANGLE_BITS'(0) - ay;
            az = ANGLE_BITS'(0) - az;
        end
    end

    mvmb_sine u_sx (.clk(clk), .en(adv), .angle(ax),           .s(sx));
    mvmb_sine u_cx (.clk(clk), .en(adv), .angle(ax + QUARTER), .s(cx));
    mvmb_sine u_sy (.clk(clk), .en(adv), .angle(ay),           .s(sy));
    mvmb_sine u_cy (.clk(clk), .en(adv), .angle(ay + QUARTER), .s(cy));
    mvmb_sine u_sz (.clk(clk), .en(adv), .angle(az),           .s(sz));
    mvmb_sine u_cz (.clk(clk), .en(adv), .angle(az + QUARTER), .s(cz));

    mvmb_rotation u_rot (
        .clk (clk),
        .en  (adv),
        .sx  (sx),
        .cx  (cx),
        .sy  (sy),
        .cy  (cy),
        .sz  (sz),
        .cz  (cz),
        .rot (rot)
    );

    mvmb_column u_col (
        .clk     (clk),
        .en      (adv),
        .rot     (rot),
        .side    (side_reg[SIDE_N]),
        .cols    (cols),
        .col_sat (col_sat)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= SIDE_N; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            buf_reg     <= cols;
            buf_sat_reg <= col_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= VAL_N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            buf_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else if (adv)
        begin
            valid_reg[1] <= s_tvalid;
            for (int k = 2; k <= VAL_N; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            buf_valid_reg <= valid_reg[VAL_N];
            col_reg       <= '0;
        end
        else if (beat)
        begin
            col_reg <= col_reg + 2'd1;
        end
    end

    assign m_tvalid = buf_valid_reg;
    assign m_tdata  = {buf_reg[col_reg][3], buf_reg[col_reg][2],
                       buf_reg[col_reg][1], buf_reg[col_reg][0]};
    assign m_tuser  = {buf_sat_reg[col_reg], col_reg};
    assign m_tlast  = (col_reg == LAST_COL);

endmodule
